### design/gdow_pkg.sv
// Shared types, constants and calendar tables for the day-of-week pipeline.
`timescale 1ns / 1ps

package gdow_pkg;

  localparam int YEAR_BITS    = 14;
  localparam int MONTH_BITS   = 4;
  localparam int DAY_BITS     = 5;
  localparam int DAY_NUM_BITS = 23;
  localparam int WDAY_BITS    = 3;
  localparam int MDAY_BITS    = 9;
  // Day count before truncation to the output width; fits any year below 2**YEAR_BITS.
  localparam int COUNT_BITS   = YEAR_BITS + 9;

  localparam int FIRST_YEAR     = 1900;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int CENTURY        = 100;
  localparam int LEAPS_BEFORE   = (FIRST_YEAR - 1) / 4 - (FIRST_YEAR - 1) / 100
                                  + (FIRST_YEAR - 1) / 400;

  // year / 100 as (year * DIV100_MULT) >> DIV100_SHIFT, exact for every year code
  localparam int     DIV100_SHIFT     = YEAR_BITS + 7;
  localparam int     MULT_BITS        = YEAR_BITS + 1;
  localparam int     PROD_BITS        = YEAR_BITS + MULT_BITS;
  localparam longint DIV100_MULT_FULL = ((longint'(1) << DIV100_SHIFT) + CENTURY - 1)
                                        / CENTURY;
  localparam logic [MULT_BITS-1:0] DIV100_MULT = MULT_BITS'(DIV100_MULT_FULL);

  // Octal digits of the day count, summed for the mod-7 reduction
  localparam int MOD7_DIGITS = (COUNT_BITS + 2) / 3;
  localparam int SUM_BITS    = 8;

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_BITS-1:0]  year;
    logic [MONTH_BITS-1:0] month;
    logic [DAY_BITS-1:0]   day;
  } in_t;

  typedef struct packed {
    logic                    date_valid;
    logic                    is_leap;
    logic [DAY_NUM_BITS-1:0] day_number;
    logic [WDAY_BITS-1:0]    weekday;
  } out_t;

  typedef struct packed {
    logic [YEAR_BITS-1:0]  year;
    logic [MONTH_BITS-1:0] month;
    logic [DAY_BITS-1:0]   day;
    logic [PROD_BITS-1:0]  prod;
  } s1_t;

  typedef struct packed {
    logic                  date_valid;
    logic                  is_leap;
    logic [COUNT_BITS-1:0] year_days;
    logic [YEAR_BITS-1:0]  leap_quarter;
    logic [YEAR_BITS-1:0]  cent;
    logic [MDAY_BITS-1:0]  mday;
  } s2_t;

  typedef struct packed {
    logic                  date_valid;
    logic                  is_leap;
    logic [COUNT_BITS-1:0] count;
  } s3_t;

  function automatic logic [MDAY_BITS-1:0] days_before_month(
    input logic [MONTH_BITS-1:0] month
  );
    logic [MDAY_BITS-1:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [DAY_BITS-1:0] month_length(
    input logic [MONTH_BITS-1:0] month,
    input logic                  leap
  );
    logic [DAY_BITS-1:0] len;
    case (month)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### design/gdow_div.sv
// Stage 1: captures the date and forms the year-by-reciprocal product for year / 100.
`timescale 1ns / 1ps

module gdow_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         stall_o,
  input  gdow_pkg::in_t data_i,
  output logic         valid_o,
  input  logic         stall_i,
  output gdow_pkg::s1_t data_o
);
  import gdow_pkg::*;

  logic valid_q;
  s1_t  data_d;
  s1_t  data_q;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    data_d.year  = data_i.year;
    data_d.month = data_i.month;
    data_d.day   = data_i.day;
    data_d.prod  = PROD_BITS'(data_i.year) * PROD_BITS'(DIV100_MULT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/gdow_date.sv
// Stage 2: leap rule, date check, day of year and whole-year day count.
`timescale 1ns / 1ps

module gdow_date (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  gdow_pkg::s1_t data_i,
  output logic          valid_o,
  input  logic          stall_i,
  output gdow_pkg::s2_t data_o
);
  import gdow_pkg::*;

  logic valid_q;
  s2_t  data_d;
  s2_t  data_q;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    logic [YEAR_BITS-1:0] q;
    logic [YEAR_BITS-1:0] hund;
    logic [YEAR_BITS-1:0] year_off;
    logic [YEAR_BITS-1:0] year_m1;
    logic                 div100;
    logic                 leap;
    logic [DAY_BITS-1:0]  len;
    q        = YEAR_BITS'(data_i.prod >> DIV100_SHIFT);
    hund     = YEAR_BITS'(q * YEAR_BITS'(CENTURY));
    div100   = (data_i.year == hund);
    // century years are leap only when the century count is a multiple of four
    leap     = (data_i.year[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
    len      = month_length(data_i.month, leap);
    year_off = data_i.year - YEAR_BITS'(FIRST_YEAR);
    year_m1  = data_i.year - YEAR_BITS'(1);

    data_d.is_leap      = leap;
    data_d.date_valid   = (data_i.year >= YEAR_BITS'(FIRST_YEAR))
                          && (data_i.month >= MONTH_JAN) && (data_i.month <= MONTH_DEC)
                          && (data_i.day != '0) && (data_i.day <= len);
    data_d.year_days    = COUNT_BITS'(year_off) * COUNT_BITS'(DAYS_PER_YEAR);
    data_d.leap_quarter = year_m1 >> 2;
    // (year - 1) / 100 from year / 100
    data_d.cent         = q - YEAR_BITS'(div100);
    data_d.mday         = days_before_month(data_i.month)
                          + MDAY_BITS'((data_i.month > MONTH_FEB) && leap)
                          + MDAY_BITS'(data_i.day);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/gdow_sum.sv
// Stage 3: adds whole years, leap days and day of year into the day count.
`timescale 1ns / 1ps

module gdow_sum (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  gdow_pkg::s2_t data_i,
  output logic          valid_o,
  input  logic          stall_i,
  output gdow_pkg::s3_t data_o
);
  import gdow_pkg::*;

  logic valid_q;
  s3_t  data_d;
  s3_t  data_q;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    logic [COUNT_BITS-1:0] leaps;
    // leap years in 1900 .. year-1
    leaps = COUNT_BITS'(data_i.leap_quarter) - COUNT_BITS'(data_i.cent)
            + COUNT_BITS'(data_i.cent >> 2) - COUNT_BITS'(LEAPS_BEFORE);
    data_d.date_valid = data_i.date_valid;
    data_d.is_leap    = data_i.is_leap;
    data_d.count      = data_i.date_valid
                        ? (data_i.year_days + leaps + COUNT_BITS'(data_i.mday))
                        : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/gdow_mod7.sv
// Stage 4: weekday as day count mod 7, using 8 == 1 (mod 7) on octal digits; output register.
`timescale 1ns / 1ps

module gdow_mod7 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  gdow_pkg::s3_t data_i,
  output logic          valid_o,
  input  logic          stall_i,
  output gdow_pkg::out_t data_o
);
  import gdow_pkg::*;

  logic valid_q;
  out_t data_d;
  out_t data_q;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    logic [MOD7_DIGITS*3-1:0] padded;
    logic [SUM_BITS-1:0]      sum;
    logic [4:0]               fold1;
    logic [3:0]               fold2;
    logic [3:0]               rem;
    padded = (MOD7_DIGITS * 3)'(data_i.count);
    sum    = '0;
    for (int i = 0; i < MOD7_DIGITS; i++) begin
      sum = sum + SUM_BITS'(padded[3*i +: 3]);
    end
    fold1 = 5'(sum[7:6]) + 5'(sum[5:3]) + 5'(sum[2:0]);
    fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);
    rem   = (fold2 >= 4'd7) ? (fold2 - 4'd7) : fold2;

    data_d.date_valid = data_i.date_valid;
    data_d.is_leap    = data_i.is_leap;
    data_d.day_number = DAY_NUM_BITS'(data_i.count);
    data_d.weekday    = WDAY_BITS'(rem);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/gregorian_day_of_week.sv
// Top level of the Gregorian date to day-number and weekday converter.
// Converts one date (year, month, day) per clock into its day number counted from
// 1 January 1900 as day 1, its weekday (0 is Sunday), a leap-year flag and a validity
// flag; day number and weekday read zero for an invalid or pre-1900 date. The path is
// four register stages: reciprocal multiply for year / 100, leap rule and date check,
// day-count sum, and mod-7 reduction into the output register. A new date is taken
// every cycle while in_stall_o is low. Each stage holds its item only while the stage
// after it is full and stalled, so empty stages keep filling while the output
// waits and no item is dropped or repeated.
`timescale 1ns / 1ps

module gregorian_day_of_week (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gdow_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gdow_pkg::out_t out_data_o
);
  import gdow_pkg::*;

  logic s1_valid;
  logic s1_stall;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_stall;
  s2_t  s2_data;
  logic s3_valid;
  logic s3_stall;
  s3_t  s3_data;

  gdow_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .stall_i (s1_stall),
    .data_o  (s1_data)
  );

  gdow_date u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stall_o (s1_stall),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .stall_i (s2_stall),
    .data_o  (s2_data)
  );

  gdow_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .stall_o (s2_stall),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .stall_i (s3_stall),
    .data_o  (s3_data)
  );

  gdow_mod7 u_mod7 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .stall_o (s3_stall),
    .data_i  (s3_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

### design/gdow_chk.sv
// Port-level assertions for the day-of-week pipeline, bound to the top level.
`timescale 1ns / 1ps

module gdow_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_i,
  input gdow_pkg::in_t  in_data_i,
  input logic           out_valid_i,
  input logic           out_stall_i,
  input gdow_pkg::out_t out_data_i
);
  import gdow_pkg::*;

  // a held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // backpressure only ever starts at a full, stalled output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled without a stalled output");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.date_valid
      |-> out_data_i.day_number == '0 && out_data_i.weekday == '0)
    else $error("invalid date with nonzero count or weekday");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.date_valid
      |-> out_data_i.day_number != '0 && out_data_i.weekday <= WDAY_BITS'(6))
    else $error("valid date with zero count or weekday out of range");

  // an accepted date passes the div, date, sum and mod7 registers and shows up at the output when nothing stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_i)
    else $error("result missing after an unstalled transfer");

endmodule

bind gregorian_day_of_week gdow_chk u_gdow_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
